FILE: sv/can_sx_pkg.sv
// Package for the CAN signal extract and scale block.
// Holds the payload geometry and the arithmetic widths shared by the RTL and its checker.
// No dependencies.
package can_sx_pkg;

  localparam int PayloadBytes = 8;
  localparam int PayloadBits  = 8 * PayloadBytes;
  localparam int WideBits     = 2 * PayloadBits;
  localparam int ShiftBits    = $clog2(WideBits);
  localparam int FactorBits   = 32;
  localparam int OffsetBits   = 48;
  localparam int ValueBits    = PayloadBits + 1;
  localparam int PartBits     = 33 + FactorBits;
  localparam int ProdBits     = ValueBits + FactorBits + 1;
  localparam int ResultBits   = 64;

  localparam logic [ResultBits-1:0] ResultMax = {1'b0, {(ResultBits-1){1'b1}}};
  localparam logic [ResultBits-1:0] ResultMin = {1'b1, {(ResultBits-1){1'b0}}};

endpackage

FILE: sv/can_signal_extract_scale.sv
// Top level of the CAN signal extract and scale block.
// Depends on can_sx_pkg for payload geometry and arithmetic widths.
//
//   channel  handshake                  payload
//   in       in_valid_i / in_stall_o    payload, byte count, signal definition, scaling
//   out      out_valid_o / out_stall_i  raw field, physical value, flags
//
// A word is accepted on every cycle while in_stall_o is low.
// The five register stages are: byte gating and bit walk set-up, field shift and
// sign extension, two partial products, product sum, offset add with saturation.
// Reset clears only the stage valid bits; the data registers are not reset.
// A stall at the output holds the whole pipeline, but empty stages still fill,
// so no word is lost or repeated.
module can_signal_extract_scale (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [can_sx_pkg::PayloadBits-1:0]     payload_i,
  input  logic [3:0]                             byte_count_i,
  input  logic [5:0]                             first_bit_i,
  input  logic [6:0]                             field_length_i,
  input  logic                                   motorola_order_i,
  input  logic                                   signed_field_i,
  input  logic signed [can_sx_pkg::FactorBits-1:0] scale_factor_i,
  input  logic signed [can_sx_pkg::OffsetBits-1:0] scale_offset_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [can_sx_pkg::PayloadBits-1:0]     raw_field_o,
  output logic signed [can_sx_pkg::ResultBits-1:0] physical_value_o,
  output logic                                   saturated_o,
  output logic                                   skipped_o
);
  import can_sx_pkg::*;

  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;

  logic [PayloadBits-1:0]       gated_d;
  logic [PayloadBits-1:0]       swapped_d;
  logic [5:0]                   moto_index_d;
  logic [WideBits-1:0]          s1_src_d, s1_src_q;
  logic [ShiftBits-1:0]         s1_shamt_d, s1_shamt_q;
  logic [6:0]                   s1_len_q;
  logic                         s1_sgn_q, s1_skip_d, s1_skip_q;
  logic signed [FactorBits-1:0] s1_factor_q, s2_factor_q;
  logic signed [OffsetBits-1:0] s1_offset_q, s2_offset_q, s3_offset_q, s4_offset_q;

  logic [WideBits-1:0]          shifted_d;
  logic [PayloadBits-1:0]       len_mask_d, field_d;
  logic [6:0]                   msb_pos_d;
  logic                         neg_d;
  logic [PayloadBits-1:0]       s2_raw_d, s2_raw_q, s3_raw_q, s4_raw_q;
  logic signed [ValueBits-1:0]  s2_value_d, s2_value_q;
  logic                         s2_skip_q, s3_skip_q, s4_skip_q;

  logic signed [PartBits-1:0]   s3_lo_d, s3_lo_q, s3_hi_d, s3_hi_q;
  logic signed [ProdBits-1:0]   s4_prod_d, s4_prod_q;

  logic signed [ProdBits-1:0]   sum_d;
  logic                         fits_d;
  logic [PayloadBits-1:0]       raw_field_d, raw_field_q;
  logic [ResultBits-1:0]        phys_d, phys_q;
  logic                         sat_d, sat_q, skipped_q;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s4_ready   = !s4_valid_q || out_ready;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  // Stage 1: gate bytes beyond the length code and set up the bit walk as one shift.
  // Motorola order becomes a plain downward shift of the byte-swapped payload.
  always_comb begin
    for (int b = 0; b < PayloadBytes; b++) begin
      gated_d[8*b +: 8] = (4'(b) < byte_count_i) ? payload_i[8*b +: 8] : 8'h00;
    end
    for (int b = 0; b < PayloadBytes; b++) begin
      swapped_d[8*b +: 8] = gated_d[8*(PayloadBytes-1-b) +: 8];
    end
    moto_index_d = {first_bit_i[5:3], ~first_bit_i[2:0]};
    if (motorola_order_i) begin
      s1_src_d   = {swapped_d, {PayloadBits{1'b0}}};
      s1_shamt_d = ShiftBits'(0) - ShiftBits'(moto_index_d) - ShiftBits'(field_length_i);
    end else begin
      s1_src_d   = {{PayloadBits{1'b0}}, gated_d};
      s1_shamt_d = ShiftBits'(first_bit_i);
    end
    s1_skip_d = (field_length_i == 7'd0) || (field_length_i > 7'(PayloadBits));
  end

  // Stage 2: extract the field and sign-extend it.
  always_comb begin
    shifted_d  = s1_src_q >> s1_shamt_q;
    len_mask_d = ~({PayloadBits{1'b1}} << s1_len_q);
    field_d    = shifted_d[PayloadBits-1:0] & len_mask_d;
    msb_pos_d  = s1_len_q - 7'd1;
    neg_d      = s1_sgn_q && field_d[msb_pos_d[5:0]];
    s2_raw_d   = s1_skip_q ? '0 : field_d;
    s2_value_d = neg_d ? $signed({1'b1, field_d | ~len_mask_d}) : $signed({1'b0, field_d});
  end

  // Stage 3: two partial products of the value with the factor.
  always_comb begin
    s3_lo_d = $signed({1'b0, s2_value_q[31:0]}) * s2_factor_q;
    s3_hi_d = $signed(s2_value_q[ValueBits-1:32]) * s2_factor_q;
  end

  // Stage 4: combine the partial products.
  assign s4_prod_d = (ProdBits'(s3_hi_q) <<< 32) + ProdBits'(s3_lo_q);

  // Stage 5: add the offset and saturate to the result width; a skipped word gives zero.
  always_comb begin
    sum_d  = s4_prod_q + ProdBits'(s4_offset_q);
    fits_d = (&sum_d[ProdBits-1:ResultBits-1]) || !(|sum_d[ProdBits-1:ResultBits-1]);
    raw_field_d = s4_raw_q;
    if (s4_skip_q) begin
      phys_d = '0;
      sat_d  = 1'b0;
    end else if (fits_d) begin
      phys_d = sum_d[ResultBits-1:0];
      sat_d  = 1'b0;
    end else begin
      phys_d = sum_d[ProdBits-1] ? ResultMin : ResultMax;
      sat_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
      if (s4_ready) s4_valid_q <= s3_valid_q;
      if (out_ready) out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_src_q    <= s1_src_d;
      s1_shamt_q  <= s1_shamt_d;
      s1_len_q    <= field_length_i;
      s1_sgn_q    <= signed_field_i;
      s1_skip_q   <= s1_skip_d;
      s1_factor_q <= scale_factor_i;
      s1_offset_q <= scale_offset_i;
    end
    if (s2_ready) begin
      s2_raw_q    <= s2_raw_d;
      s2_value_q  <= s2_value_d;
      s2_skip_q   <= s1_skip_q;
      s2_factor_q <= s1_factor_q;
      s2_offset_q <= s1_offset_q;
    end
    if (s3_ready) begin
      s3_lo_q     <= s3_lo_d;
      s3_hi_q     <= s3_hi_d;
      s3_raw_q    <= s2_raw_q;
      s3_skip_q   <= s2_skip_q;
      s3_offset_q <= s2_offset_q;
    end
    if (s4_ready) begin
      s4_prod_q   <= s4_prod_d;
      s4_raw_q    <= s3_raw_q;
      s4_skip_q   <= s3_skip_q;
      s4_offset_q <= s3_offset_q;
    end
    if (out_ready) begin
      raw_field_q <= raw_field_d;
      phys_q      <= phys_d;
      sat_q       <= sat_d;
      skipped_q   <= s4_skip_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign raw_field_o      = raw_field_q;
  assign physical_value_o = $signed(phys_q);
  assign saturated_o      = sat_q;
  assign skipped_o        = skipped_q;

endmodule

FILE: sv/can_sx_checker.sv
// Port-level checker for the CAN signal extract and scale block, with its bind.
// Depends on can_sx_pkg and on the ports of can_signal_extract_scale.
// Watches output holding, skipped and saturated results, and stall origin.
module can_sx_checker (
  input logic                                     clk_i,
  input logic                                     rst_ni,
  input logic                                     in_stall_o,
  input logic                                     out_valid_o,
  input logic                                     out_stall_i,
  input logic [can_sx_pkg::PayloadBits-1:0]       raw_field_o,
  input logic signed [can_sx_pkg::ResultBits-1:0] physical_value_o,
  input logic                                     saturated_o,
  input logic                                     skipped_o
);
  import can_sx_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(physical_value_o)
      && $stable(raw_field_o) && $stable(saturated_o) && $stable(skipped_o))
    else $error("Stalled result word changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && skipped_o |-> raw_field_o == '0 && physical_value_o == '0 && !saturated_o)
    else $error("Skipped word carries a non-zero result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      physical_value_o == $signed(ResultMax) || physical_value_o == $signed(ResultMin))
    else $error("Saturated word is not at a range limit.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled while the output was free.");

endmodule

bind can_signal_extract_scale can_sx_checker u_can_sx_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .raw_field_o      (raw_field_o),
  .physical_value_o (physical_value_o),
  .saturated_o      (saturated_o),
  .skipped_o        (skipped_o)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for can_signal_extract_scale: random and directed frames are
// decoded by an in-bench model and compared with every result word. Depends on can_sx_pkg.
module tb_top;
  import can_sx_pkg::*;

  localparam logic IntelOrder    = 1'b0;
  localparam logic MotorolaOrder = 1'b1;
  localparam int   RandomFrames  = 950;
  localparam int   IdlePercent   = 36;
  localparam int   StallLimit    = 2000;
  localparam int   DrainCycles   = 20;

  typedef struct {
    logic [PayloadBits-1:0]       payload;
    logic [3:0]                   byte_count;
    logic [5:0]                   first_bit;
    logic [6:0]                   field_length;
    logic                         order;
    logic                         signed_field;
    logic signed [FactorBits-1:0] factor;
    logic signed [OffsetBits-1:0] offset;
    bit                           drain_first;
  } frame_t;

  typedef struct {
    logic [PayloadBits-1:0]       raw;
    logic signed [ResultBits-1:0] phys;
    logic                         sat;
    logic                         skip;
  } signal_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [PayloadBits-1:0]       payload_i = '0;
  logic [3:0]                   byte_count_i = '0;
  logic [5:0]                   first_bit_i = '0;
  logic [6:0]                   field_length_i = '0;
  logic                         motorola_order_i = 1'b0;
  logic                         signed_field_i = 1'b0;
  logic signed [FactorBits-1:0] scale_factor_i = '0;
  logic signed [OffsetBits-1:0] scale_offset_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [PayloadBits-1:0]       raw_field_o;
  logic signed [ResultBits-1:0] physical_value_o;
  logic                         saturated_o;
  logic                         skipped_o;

  frame_t  frame_queue[$];
  signal_t expected_signals[$];
  frame_t  on_bus;
  int      words_sent = 0;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      idle_threshold;

  can_signal_extract_scale dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .payload_i        (payload_i),
    .byte_count_i     (byte_count_i),
    .first_bit_i      (first_bit_i),
    .field_length_i   (field_length_i),
    .motorola_order_i (motorola_order_i),
    .signed_field_i   (signed_field_i),
    .scale_factor_i   (scale_factor_i),
    .scale_offset_i   (scale_offset_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .raw_field_o      (raw_field_o),
    .physical_value_o (physical_value_o),
    .saturated_o      (saturated_o),
    .skipped_o        (skipped_o)
  );

  always #4 clk_i = ~clk_i;

  // A long stretch in the middle of the run has no idling on either side.
  assign idle_threshold = (words_sent >= 600 && words_sent < 760) ? 0 : IdlePercent;

  function automatic signal_t decode_signal(input frame_t f);
    signal_t                r;
    int unsigned            lim;
    int unsigned            pos;
    logic                   b;
    logic signed [127:0]    value;
    logic signed [127:0]    factor_w;
    logic signed [127:0]    offset_w;
    logic signed [127:0]    total;
    logic signed [127:0]    top;
    logic signed [127:0]    bottom;
    r.raw  = '0;
    r.phys = '0;
    r.sat  = 1'b0;
    r.skip = 1'b0;
    if (f.field_length == 0 || f.field_length > PayloadBits) begin
      r.skip = 1'b1;
      return r;
    end
    lim = (f.byte_count > PayloadBytes) ? PayloadBytes : f.byte_count;
    pos = f.first_bit;
    for (int k = 0; k < f.field_length; k++) begin
      if (f.order == IntelOrder) begin
        pos = f.first_bit + k;
      end
      b = ((pos >> 3) < lim) ? f.payload[pos] : 1'b0;
      if (f.order == MotorolaOrder) begin
        r.raw = {r.raw[PayloadBits-2:0], b};
        pos = ((pos & 7) == 0) ? pos + 15 : pos - 1;
      end else begin
        r.raw[k] = b;
      end
    end
    value = $signed({64'd0, r.raw});
    if (f.signed_field && r.raw[f.field_length-1]) begin
      value = value - (128'sd1 <<< f.field_length);
    end
    factor_w = f.factor;
    offset_w = f.offset;
    total    = value * factor_w + offset_w;
    top      = 128'sh7FFF_FFFF_FFFF_FFFF;
    bottom   = -top - 128'sd1;
    if (total > top) begin
      r.phys = ResultMax;
      r.sat  = 1'b1;
    end else if (total < bottom) begin
      r.phys = ResultMin;
      r.sat  = 1'b1;
    end else begin
      r.phys = total[ResultBits-1:0];
    end
    return r;
  endfunction

  task automatic add_frame(input logic [63:0] payload, input int count, input int first,
                           input int len, input logic order, input logic sgn,
                           input logic signed [31:0] factor,
                           input logic signed [47:0] offset);
    frame_t f;
    f.payload      = payload;
    f.byte_count   = 4'(count);
    f.first_bit    = 6'(first);
    f.field_length = 7'(len);
    f.order        = order;
    f.signed_field = sgn;
    f.factor       = factor;
    f.offset       = offset;
    f.drain_first  = 1'b0;
    frame_queue.insert(frame_queue.size(), f);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_signals.insert(expected_signals.size(), decode_signal(on_bus));
        words_sent <= words_sent + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (frame_queue.size() > 0 && $urandom_range(99) >= idle_threshold &&
            !(frame_queue[0].drain_first && expected_signals.size() > 0)) begin
          on_bus           <= frame_queue[0];
          payload_i        <= frame_queue[0].payload;
          byte_count_i     <= frame_queue[0].byte_count;
          first_bit_i      <= frame_queue[0].first_bit;
          field_length_i   <= frame_queue[0].field_length;
          motorola_order_i <= frame_queue[0].order;
          signed_field_i   <= frame_queue[0].signed_field;
          scale_factor_i   <= frame_queue[0].factor;
          scale_offset_i   <= frame_queue[0].offset;
          in_valid_i       <= 1'b1;
          void'(frame_queue.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    signal_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_signals.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("unexpected result word: raw %h phys %h sat %b skip %b",
                     raw_field_o, physical_value_o, saturated_o, skipped_o);
          end
        end else begin
          want = expected_signals.pop_front();
          if (raw_field_o !== want.raw || physical_value_o !== want.phys ||
              saturated_o !== want.sat || skipped_o !== want.skip) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("mismatch: raw %h/%h phys %h/%h sat %b/%b skip %b/%b (expected/actual)",
                       want.raw, raw_field_o, want.phys, physical_value_o,
                       want.sat, saturated_o, want.skip, skipped_o);
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < idle_threshold);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("tb_top: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    frame_t f;
    int     sel;
    // Full-width fields, both orders, and saturation at both ends.
    add_frame('1, 8, 0, 64, IntelOrder, 1'b0, 32'sh0001_0000, '0);
    add_frame(64'h8000_0000_0000_0000, 8, 0, 64, IntelOrder, 1'b1, 32'sh7FFF_FFFF,
              48'sh7FFF_FFFF_FFFF);
    add_frame(64'h8000_0000_0000_0000, 8, 0, 64, IntelOrder, 1'b1, 32'sh8000_0000, '0);
    add_frame('1, 8, 0, 64, IntelOrder, 1'b0, 32'sh8000_0000, 48'sh8000_0000_0000);
    add_frame('1, 8, 0, 64, IntelOrder, 1'b0, 32'sh7FFF_FFFF, 48'sh7FFF_FFFF_FFFF);
    add_frame(64'h0123_4567_89AB_CDEF, 8, 7, 64, MotorolaOrder, 1'b1, 32'sh0000_0100, '0);
    // Invalid lengths.
    add_frame('1, 8, 5, 0, IntelOrder, 1'b1, 32'sh0001_0000, 48'sh0000_1234);
    add_frame('1, 8, 5, 65, MotorolaOrder, 1'b0, 32'sh0001_0000, 48'sh0000_1234);
    add_frame('1, 8, 63, 127, IntelOrder, 1'b1, 32'sh7FFF_FFFF, 48'sh7FFF_FFFF_FFFF);
    // Motorola jump from a byte boundary, and walks that run off the payload.
    add_frame(64'hA5C3_0F1E_2D3C_4B5A, 8, 0, 16, MotorolaOrder, 1'b0, 32'sh0001_0000, '0);
    add_frame('1, 8, 63, 20, MotorolaOrder, 1'b1, 32'sh0001_0000, '0);
    add_frame('1, 8, 60, 10, IntelOrder, 1'b1, 32'sh0001_0000, '0);
    add_frame('1, 8, 56, 64, MotorolaOrder, 1'b0, 32'sh0000_0001, '0);
    // Byte count: none, partial, and above the payload size.
    add_frame('1, 0, 0, 32, IntelOrder, 1'b1, 32'sh0001_0000, 48'sh8000_0000_0000);
    add_frame('1, 3, 12, 24, IntelOrder, 1'b0, 32'sh0001_0000, '0);
    add_frame('1, 3, 23, 12, MotorolaOrder, 1'b0, 32'sh0001_0000, '0);
    add_frame(64'hF0F0_F0F0_F0F0_F0F0, 15, 32, 32, IntelOrder, 1'b0, 32'sh0001_0000, '0);
    add_frame(64'hF0F0_F0F0_F0F0_F0F0, 9, 39, 16, MotorolaOrder, 1'b1, 32'sh0001_0000, '0);
    // Sign handling on short fields and fractional scaling.
    add_frame(64'h0000_0000_0000_0001, 8, 0, 1, IntelOrder, 1'b1, 32'sh0001_0000, '0);
    add_frame(64'h0000_0000_0000_0800, 8, 0, 12, IntelOrder, 1'b1, 32'shFFFE_8000,
              48'sh0000_0003_8000);
    add_frame(64'h0000_0000_0000_0800, 8, 0, 12, IntelOrder, 1'b0, 32'sh0000_0000,
              48'sh8000_0000_0000);
    for (int n = 0; n < RandomFrames; n++) begin
      f.payload = {$urandom, $urandom};
      sel = $urandom_range(99);
      if (sel < 8) begin
        f.byte_count = 4'($urandom_range(15, 9));
      end else if (sel < 60) begin
        f.byte_count = 4'd8;
      end else begin
        f.byte_count = 4'($urandom_range(8));
      end
      f.first_bit = 6'($urandom_range(63));
      sel = $urandom_range(99);
      if (sel < 40) begin
        f.field_length = 7'($urandom_range(16, 1));
      end else if (sel < 70) begin
        f.field_length = 7'($urandom_range(48, 17));
      end else if (sel < 90) begin
        f.field_length = 7'($urandom_range(64, 49));
      end else if (sel < 93) begin
        f.field_length = 7'd0;
      end else begin
        f.field_length = 7'($urandom_range(127, 65));
      end
      f.order        = 1'($urandom_range(1));
      f.signed_field = 1'($urandom_range(1));
      f.factor = $urandom;
      if ($urandom_range(99) < 60) begin
        f.factor = $signed(f.factor) >>> $urandom_range(24, 8);
      end
      f.offset = 48'({$urandom, $urandom});
      if ($urandom_range(99) < 50) begin
        f.offset = $signed(f.offset) >>> $urandom_range(30, 8);
      end
      f.drain_first = (n == 0 || n == 400);
      frame_queue.insert(frame_queue.size(), f);
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (frame_queue.size() > 0 || in_valid_i || expected_signals.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_signals.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
